[hdl/occupancy_grid_box_fill_query_top_defines.svh]
// assertion macros shared by the checker
`ifndef OCCUPANCY_GRID_BOX_FILL_QUERY_TOP_DEFINES_SVH
`define OCCUPANCY_GRID_BOX_FILL_QUERY_TOP_DEFINES_SVH

// antecedent now, consequent in the next cycle
`define OGBFQ_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed: lbl");

// consequent in the same cycle
`define OGBFQ_ASSERT_NOW(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed: lbl");

// checked while reset is high too
`define OGBFQ_ASSERT_RST(lbl, clk, a, c) \
   lbl: assert property (@(posedge clk) (a) |=> (c)) \
      else $error("assertion failed: lbl");

`endif

[hdl/ogbfq_pkg.sv]
`default_nettype none
package ogbfq_pkg;
   localparam int MAX_BREAKPOINTS = 16;
   localparam int COORD_WIDTH     = 32;
   localparam int IDX_W           = $clog2(MAX_BREAKPOINTS);
   localparam int RANK_W          = IDX_W + 1;
   localparam int TOL_W           = 16;
   localparam int CNT_W           = 5;
   localparam int CELL_DEPTH      = MAX_BREAKPOINTS * MAX_BREAKPOINTS;
   localparam int CELL_AW         = 2 * IDX_W;
   localparam int QDEPTH          = 2;
   localparam int QAW             = 1;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_FILL  = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_X_MIS = 2'd1;
   localparam logic [1:0] ST_Y_MIS = 2'd2;
   localparam logic [1:0] ST_Z_MIS = 2'd3;

   localparam logic [1:0] CSR_X_COUNT = 2'd0;
   localparam logic [1:0] CSR_Y_COUNT = 2'd1;
   localparam logic [1:0] CSR_Z_COUNT = 2'd2;
   localparam logic [1:0] CSR_TOL     = 2'd3;

   typedef enum logic [1:0] {OP_DONE, OP_FILL, OP_QUERY} op_type;

   typedef struct packed {
      op_type                  op;
      logic [1:0]              status;
      logic                    box_in;
      logic [RANK_W-1:0]       i_lo;
      logic [RANK_W-1:0]       i_hi;
      logic [RANK_W-1:0]       j_lo;
      logic [RANK_W-1:0]       j_hi;
      logic [MAX_BREAKPOINTS-1:0] mask;
   } cmd_type;

   typedef enum logic [1:0] {F_IDLE, F_SCAN, F_PUSH} front_state_type;
   typedef enum logic [1:0] {B_IDLE, B_READ, B_CHECK, B_RESP} back_state_type;
endpackage
`default_nettype wire

[hdl/ogbfq_ram.sv]
`default_nettype none
module ogbfq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

[hdl/ogbfq_front.sv]
`default_nettype none
module ogbfq_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [1:0]                            req_type,
   input  wire logic [1:0]                            axis_select,
   input  wire logic [ogbfq_pkg::IDX_W-1:0]           table_slot,
   input  wire logic [ogbfq_pkg::COORD_WIDTH-1:0]     breakpoint_value,
   input  wire logic [ogbfq_pkg::COORD_WIDTH-1:0]     lo_bound [3],
   input  wire logic [ogbfq_pkg::COORD_WIDTH-1:0]     hi_bound [3],
   input  wire logic [ogbfq_pkg::RANK_W-1:0]          count [3],
   input  wire logic [ogbfq_pkg::TOL_W-1:0]           tolerance,
   input  wire logic                                  q_full,
   output logic                                       q_push,
   output ogbfq_pkg::cmd_type                         q_cmd
);
   localparam int CW = ogbfq_pkg::COORD_WIDTH;
   localparam int NB = ogbfq_pkg::MAX_BREAKPOINTS;
   localparam int RW = ogbfq_pkg::RANK_W;
   localparam int IW = ogbfq_pkg::IDX_W;
   localparam int TOL_W_L = ogbfq_pkg::TOL_W;

   ogbfq_pkg::front_state_type state_ff, state_in;
   logic [CW-1:0] tab_ff [3][NB];
   logic [1:0]    type_ff;
   logic [CW-1:0] lo_ff [3], hi_ff [3];
   logic [RW-1:0] n_ff [3];
   logic [TOL_W_L-1:0] tol_ff;
   logic [IW-1:0] slot_ff, slot_in;
   logic          fl_ff [3], fh_ff [3], fl_in [3], fh_in [3];
   logic [IW-1:0] il_ff [3], ih_ff [3], il_in [3], ih_in [3];
   logic [RW-1:0] ra_ff [3], rb_ff [3], ra_in [3], rb_in [3];
   logic          accept;
   logic          ax_ok [3];
   logic [RW-1:0] k_lo, k_hi;

   assign busy   = (state_ff != ogbfq_pkg::F_IDLE);
   assign accept = start && !busy;

   // one table entry per axis each scan cycle
   always_comb begin
      logic signed [CW+1:0] b_ext, lo_t, hi_ext, b_t;
      logic                 live;
      for (int a = 0; a < 3; a++) begin
         fl_in[a] = fl_ff[a];
         fh_in[a] = fh_ff[a];
         il_in[a] = il_ff[a];
         ih_in[a] = ih_ff[a];
         ra_in[a] = ra_ff[a];
         rb_in[a] = rb_ff[a];
         b_ext  = {{2{tab_ff[a][slot_ff][CW-1]}}, tab_ff[a][slot_ff]};
         lo_t   = {{2{lo_ff[a][CW-1]}}, lo_ff[a]} + (CW+2)'(tol_ff);
         hi_ext = {{2{hi_ff[a][CW-1]}}, hi_ff[a]};
         b_t    = b_ext + (CW+2)'(tol_ff);
         live   = ({1'b0, slot_ff} < n_ff[a]);
         if (accept) begin
            fl_in[a] = 1'b0;
            fh_in[a] = 1'b0;
            ra_in[a] = '0;
            rb_in[a] = '0;
         end else if (state_ff == ogbfq_pkg::F_SCAN && live) begin
            if (!fl_ff[a] && tab_ff[a][slot_ff] == lo_ff[a]) begin
               fl_in[a] = 1'b1;
               il_in[a] = slot_ff;
            end
            if (!fh_ff[a] && tab_ff[a][slot_ff] == hi_ff[a]) begin
               fh_in[a] = 1'b1;
               ih_in[a] = slot_ff;
            end
            if (lo_t > b_ext) begin
               ra_in[a] = ra_ff[a] + RW'(1);
            end
            if (hi_ext > b_t) begin
               rb_in[a] = rb_ff[a] + RW'(1);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      q_push   = 1'b0;
      q_cmd    = '0;
      k_lo     = '0;
      k_hi     = '0;
      for (int a = 0; a < 3; a++) begin
         ax_ok[a] = (ra_ff[a] != '0) && (ra_ff[a] != n_ff[a]) &&
                    (rb_ff[a] != '0) && (rb_ff[a] != n_ff[a]);
      end
      case (state_ff)
         ogbfq_pkg::F_IDLE: begin
            slot_in = '0;
            if (accept) begin
               if (req_type inside {ogbfq_pkg::REQ_FILL, ogbfq_pkg::REQ_QUERY}) begin
                  state_in = ogbfq_pkg::F_SCAN;
               end else begin
                  state_in = ogbfq_pkg::F_PUSH;
               end
            end
         end
         ogbfq_pkg::F_SCAN: begin
            slot_in = slot_ff + IW'(1);
            if (slot_ff == IW'(NB - 1)) begin
               state_in = ogbfq_pkg::F_PUSH;
            end
         end
         ogbfq_pkg::F_PUSH: begin
            q_cmd.op = ogbfq_pkg::OP_DONE;
            if (type_ff == ogbfq_pkg::REQ_FILL) begin
               if (!(fl_ff[0] && fh_ff[0])) begin
                  q_cmd.status = ogbfq_pkg::ST_X_MIS;
               end else if (!(fl_ff[1] && fh_ff[1])) begin
                  q_cmd.status = ogbfq_pkg::ST_Y_MIS;
               end else if (!(fl_ff[2] && fh_ff[2])) begin
                  q_cmd.status = ogbfq_pkg::ST_Z_MIS;
               end else begin
                  q_cmd.op   = ogbfq_pkg::OP_FILL;
                  q_cmd.i_lo = {1'b0, il_ff[0]};
                  q_cmd.i_hi = {1'b0, ih_ff[0]};
                  q_cmd.j_lo = {1'b0, il_ff[1]};
                  q_cmd.j_hi = {1'b0, ih_ff[1]};
                  k_lo       = {1'b0, il_ff[2]};
                  k_hi       = {1'b0, ih_ff[2]};
               end
            end else if (type_ff == ogbfq_pkg::REQ_QUERY) begin
               if (ax_ok[0] && ax_ok[1] && ax_ok[2]) begin
                  q_cmd.op   = ogbfq_pkg::OP_QUERY;
                  q_cmd.i_lo = ra_ff[0] - RW'(1);
                  q_cmd.i_hi = rb_ff[0];
                  q_cmd.j_lo = ra_ff[1] - RW'(1);
                  q_cmd.j_hi = rb_ff[1];
                  k_lo       = ra_ff[2] - RW'(1);
                  k_hi       = rb_ff[2];
               end
            end
            for (int k = 0; k < NB; k++) begin
               q_cmd.mask[k] = (RW'(k) >= k_lo) && (RW'(k) < k_hi);
            end
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = ogbfq_pkg::F_IDLE;
            end
         end
         default: state_in = ogbfq_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ogbfq_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      for (int a = 0; a < 3; a++) begin
         fl_ff[a] <= fl_in[a];
         fh_ff[a] <= fh_in[a];
         il_ff[a] <= il_in[a];
         ih_ff[a] <= ih_in[a];
         ra_ff[a] <= ra_in[a];
         rb_ff[a] <= rb_in[a];
      end
      if (accept) begin
         type_ff <= req_type;
         tol_ff  <= tolerance;
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= lo_bound[a];
            hi_ff[a] <= hi_bound[a];
            n_ff[a]  <= count[a];
         end
         if (req_type == ogbfq_pkg::REQ_LOAD) begin
            case (axis_select)
               ogbfq_pkg::AXIS_X: tab_ff[0][table_slot] <= breakpoint_value;
               ogbfq_pkg::AXIS_Y: tab_ff[1][table_slot] <= breakpoint_value;
               ogbfq_pkg::AXIS_Z: tab_ff[2][table_slot] <= breakpoint_value;
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

[hdl/ogbfq_queue.sv]
`default_nettype none
module ogbfq_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ogbfq_pkg::cmd_type push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output ogbfq_pkg::cmd_type      head
);
   localparam int AW = ogbfq_pkg::QAW;

   ogbfq_pkg::cmd_type slot_ff [ogbfq_pkg::QDEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   fill_ff;

   assign full  = (fill_ff == (AW+1)'(ogbfq_pkg::QDEPTH));
   assign empty = (fill_ff == '0);
   assign head  = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push && !full) begin
            wp_ff <= wp_ff + AW'(1);
         end
         if (pop && !empty) begin
            rp_ff <= rp_ff + AW'(1);
         end
         fill_ff <= fill_ff + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wp_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

[hdl/ogbfq_back.sv]
`default_nettype none
module ogbfq_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire ogbfq_pkg::cmd_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic                    rsp_box_inside
);
   localparam int RW = ogbfq_pkg::RANK_W;
   localparam int IW = ogbfq_pkg::IDX_W;
   localparam int AW = ogbfq_pkg::CELL_AW;
   localparam int NB = ogbfq_pkg::MAX_BREAKPOINTS;

   ogbfq_pkg::back_state_type state_ff, state_in;
   ogbfq_pkg::cmd_type cmd_ff, cmd_in;
   logic [RW-1:0] i_ff, i_in, j_ff, j_in;
   logic [1:0]    status_ff, status_in;
   logic          box_in_ff, box_in_in;
   logic [ogbfq_pkg::CELL_DEPTH-1:0] vld_ff;
   logic          rv_ff;
   logic          we;
   logic [AW-1:0] addr;
   logic [NB-1:0] rdata, word, wdata;
   logic          last_j, last_i;

   assign addr  = {i_ff[IW-1:0], j_ff[IW-1:0]};
   assign word  = rv_ff ? rdata : '0;
   assign wdata = word | cmd_ff.mask;

   ogbfq_ram #(.WIDTH(NB), .DEPTH(ogbfq_pkg::CELL_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (addr),
      .wdata (wdata),
      .raddr (addr),
      .rdata (rdata)
   );

   assign rsp_valid      = (state_ff == ogbfq_pkg::B_RESP);
   assign rsp_status     = status_ff;
   assign rsp_box_inside = box_in_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      status_in = status_ff;
      box_in_in = box_in_ff;
      q_pop     = 1'b0;
      we        = 1'b0;
      last_j    = (j_ff + RW'(1) >= cmd_ff.j_hi);
      last_i    = (i_ff + RW'(1) >= cmd_ff.i_hi);
      case (state_ff)
         ogbfq_pkg::B_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               cmd_in    = q_head;
               i_in      = q_head.i_lo;
               j_in      = q_head.j_lo;
               status_in = q_head.status;
               box_in_in = q_head.box_in;
               if (q_head.op == ogbfq_pkg::OP_DONE) begin
                  state_in = ogbfq_pkg::B_RESP;
               end else begin
                  status_in = ogbfq_pkg::ST_OK;
                  box_in_in = (q_head.op == ogbfq_pkg::OP_QUERY);
                  if (q_head.i_lo >= q_head.i_hi || q_head.j_lo >= q_head.j_hi) begin
                     state_in = ogbfq_pkg::B_RESP;
                  end else begin
                     state_in = ogbfq_pkg::B_READ;
                  end
               end
            end
         end
         ogbfq_pkg::B_READ: state_in = ogbfq_pkg::B_CHECK;
         ogbfq_pkg::B_CHECK: begin
            state_in = ogbfq_pkg::B_READ;
            if (cmd_ff.op == ogbfq_pkg::OP_FILL) begin
               we = 1'b1;
            end else if (word == '0 || (word & cmd_ff.mask) != cmd_ff.mask) begin
               box_in_in = 1'b0;
               state_in  = ogbfq_pkg::B_RESP;
            end
            if (state_in == ogbfq_pkg::B_READ) begin
               if (last_j) begin
                  j_in = cmd_ff.j_lo;
                  i_in = i_ff + RW'(1);
                  if (last_i) begin
                     state_in = ogbfq_pkg::B_RESP;
                  end
               end else begin
                  j_in = j_ff + RW'(1);
               end
            end
         end
         ogbfq_pkg::B_RESP: state_in = ogbfq_pkg::B_IDLE;
         default: state_in = ogbfq_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ogbfq_pkg::B_IDLE;
         vld_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (we) begin
            vld_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      status_ff <= status_in;
      box_in_ff <= box_in_in;
      rv_ff     <= vld_ff[addr];
   end
endmodule
`default_nettype wire

[hdl/occupancy_grid_box_fill_query_top.sv]
`default_nettype none
// occupancy grid with box fill and box query
// input channel: start with req_* fields, taken when start is high and busy low
// load item: writes one breakpoint of the selected axis table
// fill item: all six bounds must equal breakpoints; marks the cell box
// query item: tolerant ranks per axis, reports whether every cell is active
// each item gives exactly one result: rsp_valid high for one cycle with
// rsp_status and rsp_box_inside; the receiver cannot stall, results are in order
// csr port: csr_wr_en, csr_index, csr_wdata; write only while idle
// front: a load goes straight to the push state, a fill or query scans the 16 table
// slots first; then it pushes one command into a 2-entry queue, waiting while it is full
// back: each cell word takes a registered ram read, then a check or write, over
// every cell of the x and y range in turn
// a query stops early at the first missing cell
// reset clears control state and the per-word valid bits of the occupancy
// store, so the grid reads as empty at once: no clearing pass
module occupancy_grid_box_fill_query_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [1:0]  req_axis_select,
   input  wire logic [3:0]  req_table_slot,
   input  wire logic [31:0] req_breakpoint_value,
   input  wire logic [31:0] req_x_low,
   input  wire logic [31:0] req_x_high,
   input  wire logic [31:0] req_y_low,
   input  wire logic [31:0] req_y_high,
   input  wire logic [31:0] req_z_low,
   input  wire logic [31:0] req_z_high,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_box_inside,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int RW = ogbfq_pkg::RANK_W;
   localparam int CN = ogbfq_pkg::CNT_W;

   // configuration registers
   logic [CN-1:0] cnt_ff [3];
   logic [ogbfq_pkg::TOL_W-1:0] tol_ff;
   logic [RW-1:0] count [3];
   logic [31:0]   lo_bound [3], hi_bound [3];

   // queue between front and back
   logic               q_push, q_full, q_pop, q_empty;
   ogbfq_pkg::cmd_type q_cmd, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         cnt_ff[2] <= '0;
         tol_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            ogbfq_pkg::CSR_X_COUNT: cnt_ff[0] <= csr_wdata[CN-1:0];
            ogbfq_pkg::CSR_Y_COUNT: cnt_ff[1] <= csr_wdata[CN-1:0];
            ogbfq_pkg::CSR_Z_COUNT: cnt_ff[2] <= csr_wdata[CN-1:0];
            ogbfq_pkg::CSR_TOL:     tol_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // counts above the table size act as a full table
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         count[a] = (cnt_ff[a] > CN'(ogbfq_pkg::MAX_BREAKPOINTS)) ?
                    RW'(ogbfq_pkg::MAX_BREAKPOINTS) : RW'(cnt_ff[a]);
      end
   end

   assign lo_bound[0] = req_x_low;
   assign lo_bound[1] = req_y_low;
   assign lo_bound[2] = req_z_low;
   assign hi_bound[0] = req_x_high;
   assign hi_bound[1] = req_y_high;
   assign hi_bound[2] = req_z_high;

   ogbfq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .axis_select      (req_axis_select),
      .table_slot       (req_table_slot),
      .breakpoint_value (req_breakpoint_value),
      .lo_bound         (lo_bound),
      .hi_bound         (hi_bound),
      .count            (count),
      .tolerance        (tol_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_cmd)
   );

   ogbfq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   ogbfq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_box_inside (rsp_box_inside)
   );
endmodule
`default_nettype wire

[hdl/ogbfq_checker.sv]
`default_nettype none
`include "occupancy_grid_box_fill_query_top_defines.svh"
module ogbfq_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_box_inside
);
   // an accepted item keeps the front busy next cycle
   `OGBFQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // results never come in adjacent cycles
   `OGBFQ_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)
   // a positive query answer never carries a misalignment status
   `OGBFQ_ASSERT_NOW(a_inside_ok, clock, reset, rsp_valid && rsp_box_inside,
      rsp_status == ogbfq_pkg::ST_OK)
   // reset leaves the block idle with no result
   `OGBFQ_ASSERT_RST(a_reset_idle, clock, reset, !busy && !rsp_valid)
endmodule

bind occupancy_grid_box_fill_query_top ogbfq_checker u_checker (.*);
`default_nettype wire
